### src/slbe_pkg.sv
// Shared types, constants and saturation helpers for the best-edges unit.
package slbe_pkg;

	localparam int MAX_WORD    = 10;
	localparam int TOP_EDGES   = 5;
	localparam int SCORE_W     = 24;
	localparam int WORD_W      = 28;
	localparam int PATH_W      = 40;
	localparam int LEN_W       = 4;
	localparam int RANK_W      = 3;
	localparam int KEEP_W      = 3;
	localparam int CFG_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int IDX_W       = $clog2(MAX_WORD);
	localparam int ACC_W       = SCORE_W + $clog2(MAX_WORD + 1) + 1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_WORD_LEN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT   = 1'd1;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score_begin;
		logic signed [SCORE_W-1:0] score_middle;
		logic signed [SCORE_W-1:0] score_end;
		logic signed [SCORE_W-1:0] score_single;
		logic                      sentence_start;
	} in_item_t;

	typedef struct packed {
		logic        [LEN_W-1:0]  word_length;
		logic signed [WORD_W-1:0] word_score;
		logic signed [PATH_W-1:0] path_score;
		logic        [RANK_W-1:0] edge_rank;
		logic                     last_edge;
	} out_item_t;

	typedef struct packed {
		logic        [LEN_W-1:0]  len;
		logic signed [WORD_W-1:0] word;
		logic signed [PATH_W-1:0] path;
	} edge_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] b;
		logic signed [SCORE_W-1:0] m;
		logic signed [PATH_W-1:0]  p;
	} hist_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'({1'b0, {(WORD_W-1){1'b1}}});
		lo = -hi - ACC_W'(1);
		if (v > hi)
			return {1'b0, {(WORD_W-1){1'b1}}};
		else if (v < lo)
			return {1'b1, {(WORD_W-1){1'b0}}};
		else
			return v[WORD_W-1:0];
	endfunction

	function automatic logic signed [PATH_W-1:0] sat_path(input logic signed [PATH_W:0] v);
		if (v[PATH_W] != v[PATH_W-1])
			return v[PATH_W] ? {1'b1, {(PATH_W-1){1'b0}}} : {1'b0, {(PATH_W-1){1'b1}}};
		else
			return v[PATH_W-1:0];
	endfunction

endpackage

### src/slbe_hist_cell.sv
// One history cell: B, M and best-prefix scores of one past character.
module slbe_hist_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  slbe_pkg::hist_t d,
	output slbe_pkg::hist_t q
);
	import slbe_pkg::*;

	hist_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (shift) begin
			ent_q <= d;
		end
	end

	assign q = ent_q;

endmodule

### src/slbe_sort_cell.sv
// One insertion-sort cell: holds one ranked edge, yields to better candidates.
module slbe_sort_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clear,
	input  logic            step,
	input  logic            active,
	input  slbe_pkg::edge_t cand,
	input  logic            prev_hold,
	input  logic            prev_valid,
	input  slbe_pkg::edge_t prev_edge,
	output logic            hold,
	output logic            valid,
	output slbe_pkg::edge_t edge_q
);
	import slbe_pkg::*;

	logic  valid_q;
	edge_t ent_q;

	// stable: an equal score stays ahead of the later (longer) candidate
	assign hold = valid_q && (ent_q.path >= cand.path);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (step) begin
			if (!active)
				valid_q <= 1'b0;
			else if (!hold)
				valid_q <= prev_hold ? 1'b1 : prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && active && !hold) begin
			ent_q <= prev_hold ? cand : prev_edge;
		end
	end

	assign valid  = valid_q;
	assign edge_q = ent_q;

endmodule

### src/segment_lattice_best_edges_unit.sv
// Top level of the word-lattice best-edges unit.
//
// Each input transaction carries one character's B/M/E/S tag scores (Q12.12)
// and a sentence-start flag. For every word length 1..min(max_word_len,
// characters so far in the sentence) the unit forms the word score and the
// path score (best prefix before the word plus word score, saturating at 40
// bits) and feeds it to a row of insertion-sort cells that keeps the best
// keep_count edges, ties in length order. The edges then leave best first,
// one output transaction each, with last_edge on the final one. A character
// passes through four states: idle, which takes the input; sweep, one word
// length per cycle for each of the L lengths through the shared adder and
// the sort-cell row; update, which shifts the history cells; and emit, which
// sends K = min(L, keep_count) edges; a stalled output stretches the emit
// phase. The next character is taken once all edges of the current one sit
// in or have left the output register.
module segment_lattice_best_edges_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [slbe_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [slbe_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  slbe_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output slbe_pkg::out_item_t                out_data
);
	import slbe_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	logic [1:0]  state_q;

	// config registers
	logic [LEN_W-1:0]  max_len_q;
	logic [KEEP_W-1:0] keep_q;

	// latched character
	in_item_t          item_q;
	logic [LEN_W-1:0]  chars_q;    // chars of sentence before this one
	logic [LEN_W-1:0]  lim_q;
	logic [LEN_W-1:0]  len_q;      // current sweep length
	logic [KEEP_W-1:0] keep_eff_q;
	logic [KEEP_W-1:0] n_q;
	logic [KEEP_W-1:0] k_q;
	logic signed [ACC_W-1:0] msum_q;

	out_item_t out_q;
	logic      out_valid_q;

	// history cells
	hist_t hist   [MAX_WORD];
	hist_t hist_d [MAX_WORD];
	logic  hist_shift;

	// sort cells
	edge_t cell_edge  [TOP_EDGES];
	logic  cell_valid [TOP_EDGES];
	logic  cell_hold  [TOP_EDGES];
	edge_t cand;

	logic accept;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);

	// effective limits for a new character
	logic [LEN_W-1:0]  chars_eff;
	logic [LEN_W-1:0]  max_eff;
	logic [LEN_W-1:0]  lim_new;
	logic [KEEP_W-1:0] keep_new;

	always_comb begin
		chars_eff = in_data.sentence_start ? '0 : chars_q;
		if (max_len_q == '0)
			max_eff = LEN_W'(1);
		else if (max_len_q > LEN_W'(MAX_WORD))
			max_eff = LEN_W'(MAX_WORD);
		else
			max_eff = max_len_q;
		lim_new = (max_eff > chars_eff + LEN_W'(1)) ? chars_eff + LEN_W'(1) : max_eff;
		if (keep_q == '0)
			keep_new = KEEP_W'(1);
		else if (keep_q > KEEP_W'(TOP_EDGES))
			keep_new = KEEP_W'(TOP_EDGES);
		else
			keep_new = keep_q;
	end

	// candidate edge for length len_q
	logic [IDX_W-1:0]        bidx;
	logic [IDX_W-1:0]        pidx;
	logic signed [ACC_W-1:0] w_raw;
	logic signed [WORD_W-1:0] w_sat;
	logic signed [PATH_W-1:0] pre;

	always_comb begin
		bidx = (len_q >= LEN_W'(2)) ? IDX_W'(len_q - LEN_W'(2)) : '0;
		pidx = IDX_W'(len_q - LEN_W'(1));
		if (len_q == LEN_W'(1))
			w_raw = ACC_W'(item_q.score_single);
		else
			w_raw = ACC_W'(item_q.score_end) + ACC_W'(hist[bidx].b) + msum_q;
		w_sat = sat_word(w_raw);
		pre   = (len_q - LEN_W'(1) < chars_q) ? hist[pidx].p : '0;
		cand.len  = len_q;
		cand.word = w_sat;
		cand.path = sat_path(PATH_W'(pre) + (PATH_W+1)'(w_sat) + {pre[PATH_W-1], {PATH_W{1'b0}}});
	end

	// history row: newest at index 0
	assign hist_shift = (state_q == ST_UPDATE);
	always_comb begin
		hist_d[0].b = item_q.score_begin;
		hist_d[0].m = item_q.score_middle;
		hist_d[0].p = cell_edge[0].path;
		for (int i = 1; i < MAX_WORD; i++)
			hist_d[i] = hist[i-1];
	end

	for (genvar g = 0; g < MAX_WORD; g++) begin : g_hist
		slbe_hist_cell u_hist (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (hist_shift),
			.d      (hist_d[g]),
			.q      (hist[g])
		);
	end

	// sort row: rank 0 at index 0, candidates ripple toward higher ranks
	for (genvar g = 0; g < TOP_EDGES; g++) begin : g_sort
		if (g == 0) begin : g_head
			slbe_sort_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.clear      (accept),
				.step       (state_q == ST_SWEEP),
				.active     (1'b1),
				.cand       (cand),
				.prev_hold  (1'b1),
				.prev_valid (1'b0),
				.prev_edge  (cand),
				.hold       (cell_hold[g]),
				.valid      (cell_valid[g]),
				.edge_q     (cell_edge[g])
			);
		end else begin : g_tail
			slbe_sort_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.clear      (accept),
				.step       (state_q == ST_SWEEP),
				.active     (KEEP_W'(g) < keep_eff_q),
				.cand       (cand),
				.prev_hold  (cell_hold[g-1]),
				.prev_valid (cell_valid[g-1]),
				.prev_edge  (cell_edge[g-1]),
				.hold       (cell_hold[g]),
				.valid      (cell_valid[g]),
				.edge_q     (cell_edge[g])
			);
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LEN_W'(MAX_WORD);
			keep_q    <= KEEP_W'(TOP_EDGES);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_WORD_LEN: max_len_q <= cfg_wdata[LEN_W-1:0];
				REG_KEEP_COUNT:   keep_q    <= cfg_wdata[KEEP_W-1:0];
				default: ;
			endcase
		end
	end

	logic load_out;
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (accept)
			item_q <= in_data;
		if (load_out) begin
			out_q.word_length <= cell_edge[k_q].len;
			out_q.word_score  <= cell_edge[k_q].word;
			out_q.path_score  <= cell_edge[k_q].path;
			out_q.edge_rank   <= RANK_W'(k_q);
			out_q.last_edge   <= (k_q + KEEP_W'(1) == n_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chars_q     <= '0;
			lim_q       <= '0;
			len_q       <= '0;
			keep_eff_q  <= '0;
			n_q         <= '0;
			k_q         <= '0;
			msum_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						chars_q    <= chars_eff;
						lim_q      <= lim_new;
						keep_eff_q <= keep_new;
						len_q      <= LEN_W'(1);
						msum_q     <= '0;
						state_q    <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (len_q >= LEN_W'(2))
						msum_q <= msum_q + ACC_W'(hist[bidx].m);
					len_q <= len_q + LEN_W'(1);
					if (len_q == lim_q)
						state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (chars_q < LEN_W'(MAX_WORD - 1))
						chars_q <= chars_q + LEN_W'(1);
					n_q     <= (lim_q < LEN_W'(keep_eff_q)) ? KEEP_W'(lim_q) : keep_eff_q;
					k_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						k_q         <= k_q + KEEP_W'(1);
						if (k_q + KEEP_W'(1) == n_q)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
